// ----- src/tmr_pkg.sv -----
// ----------------------------------------------------------------------------
// tmr_pkg: shared types and constants of the timer table
// Request and event codes, the control bundle broadcast to every timer cell
// and the search token passed along the row of cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tmr_pkg;

  localparam int ID_W        = 32;
  localparam int DELAY_W     = 31;
  localparam int RELOAD_W    = 31;
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_TICK   = 2'd2
  } req_t;

  typedef enum logic [2:0] {
    EV_ADDED    = 3'd0,
    EV_FULL     = 3'd1,
    EV_REMOVED  = 3'd2,
    EV_NOTFOUND = 3'd3,
    EV_EXPIRED  = 3'd4,
    EV_IDLE     = 3'd5
  } event_t;

  // Commands broadcast to all cells; the addressed cell compares the hit index.
  typedef struct packed {
    logic latch_due;
    logic wr;
    logic clr;
    logic expire;
    req_t mode;
  } cell_ctl_t;

  // Best candidate found so far along the row.
  typedef struct packed {
    logic            found;
    logic [ID_W-1:0] id;
  } tok_t;

endpackage

`default_nettype wire

// ----- src/tmr_cell.sv -----
// ----------------------------------------------------------------------------
// tmr_cell: one timer slot
// Holds the slot state, applies broadcast commands addressed to it and
// forwards the registered search token to its right-hand neighbor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tmr_cell #(
  parameter int TIME_BITS = 40,
  parameter int IDX_W     = 4,
  parameter int INDEX     = 0
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  tmr_pkg::cell_ctl_t           ctl,
  input  wire  [IDX_W-1:0]             hit_idx,
  input  wire  [tmr_pkg::ID_W-1:0]     wr_id,
  input  wire  [TIME_BITS-1:0]         wr_exp,
  input  wire  [tmr_pkg::RELOAD_W-1:0] wr_rel,
  input  wire  [TIME_BITS-1:0]         now_ms,
  input  wire  [tmr_pkg::ID_W-1:0]     target_id,
  input  tmr_pkg::tok_t                tok_in,
  input  wire  [IDX_W-1:0]             idx_in,
  output tmr_pkg::tok_t                tok_out,
  output logic [IDX_W-1:0]             idx_out
);
  import tmr_pkg::*;

  logic                valid_r, valid_nxt;
  logic                due_r, due_nxt;
  logic [ID_W-1:0]     id_r, id_nxt;
  logic [TIME_BITS-1:0] exp_r, exp_nxt;
  logic [RELOAD_W-1:0] rel_r, rel_nxt;
  tok_t                tok_r, tok_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;

  logic sel;
  logic own_key;
  logic take_own;

  assign sel = (hit_idx == IDX_W'(INDEX));

  always_comb begin
    valid_nxt = valid_r;
    due_nxt   = due_r;
    id_nxt    = id_r;
    exp_nxt   = exp_r;
    rel_nxt   = rel_r;
    if (ctl.latch_due) begin
      due_nxt = valid_r && (exp_r <= now_ms);
    end
    if (sel && ctl.wr) begin
      valid_nxt = 1'b1;
      id_nxt    = wr_id;
      exp_nxt   = wr_exp;
      rel_nxt   = wr_rel;
    end
    if (sel && ctl.clr) begin
      valid_nxt = 1'b0;
    end
    if (sel && ctl.expire) begin
      due_nxt = 1'b0;
      if (rel_r != '0) begin
        exp_nxt = now_ms + TIME_BITS'(rel_r);
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  // Free and match searches keep the lowest slot; the due search keeps the
  // smallest id, with the lower slot winning a tie.
  always_comb begin
    case (ctl.mode)
      REQ_ADD:    own_key = !valid_r;
      REQ_REMOVE: own_key = valid_r && (id_r == target_id);
      REQ_TICK:   own_key = due_r;
      default:    own_key = 1'b0;
    endcase
    take_own = own_key && (!tok_in.found || ((ctl.mode == REQ_TICK) && (id_r < tok_in.id)));
    if (take_own) begin
      tok_nxt.found = 1'b1;
      tok_nxt.id    = id_r;
      idx_nxt       = IDX_W'(INDEX);
    end else begin
      tok_nxt = tok_in;
      idx_nxt = idx_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      due_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      due_r   <= due_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r  <= id_nxt;
    exp_r <= exp_nxt;
    rel_r <= rel_nxt;
    tok_r <= tok_nxt;
    idx_r <= idx_nxt;
  end

  assign tok_out = tok_r;
  assign idx_out = idx_r;

endmodule

`default_nettype wire

// ----- src/timer_table_oneshot_periodic_core.sv -----
// ----------------------------------------------------------------------------
// timer_table_oneshot_periodic_core: table of one-shot and periodic timers
// Add, remove and millisecond tick requests over a row of timer cells; every
// search is a token that ripples through the row one cell per cycle.
// ----------------------------------------------------------------------------
// Add and remove give their single result after one pass of the token across the row.
// A tick sends the token across the row once for every expiry, up to 16 expiries,
// and once more to find nothing left due when fewer than 16 expired; output stalls
// can hold it before each expiry result and before the last one.
// One item is in work at a time; the next is taken while the last result waits.
// Reset (synchronous, rst_n low) frees all slots and zeroes time and id counter.
`timescale 1ns / 1ps
`default_nettype none

module timer_table_oneshot_periodic_core #(
  parameter int NUM_TIMERS = 16,
  parameter int TIME_BITS  = 40
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [95:0] in_tdata,   // delay_ms[30:0], reload_ms[61:31], target_id[93:62]
  input  wire  [1:0]  in_tuser,   // req_type[1:0]
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [31:0] out_tdata,  // timer_id[31:0]
  output logic [2:0]  out_tuser,  // event_kind[2:0]
  output logic        out_tlast
);
  import tmr_pkg::*;

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int SCN_W = $clog2(NUM_TIMERS + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DUE  = 5'b00010,
    S_SCAN = 5'b00100,
    S_PUSH = 5'b01000,
    S_LAST = 5'b10000
  } state_t;

  state_t               state_r, state_nxt;
  logic [TIME_BITS-1:0] now_r, now_nxt;
  logic [ID_W-1:0]      idc_r, idc_nxt;
  req_t                 mode_r, mode_nxt;
  logic [DELAY_W-1:0]   delay_r, delay_nxt;
  logic [RELOAD_W-1:0]  reload_r, reload_nxt;
  logic [ID_W-1:0]      target_r, target_nxt;
  logic [SCN_W-1:0]     scan_cnt_r, scan_cnt_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 have_r, have_nxt;
  event_t               pend_kind_r, pend_kind_nxt;
  logic [ID_W-1:0]      pend_id_r, pend_id_nxt;
  logic                 out_valid_r, out_valid_nxt;
  event_t               out_kind_r, out_kind_nxt;
  logic [ID_W-1:0]      out_id_r, out_id_nxt;
  logic                 out_last_r, out_last_nxt;

  cell_ctl_t            ctl;
  tok_t                 tok [0:NUM_TIMERS];
  logic [IDX_W-1:0]     idx [0:NUM_TIMERS];
  logic [TIME_BITS-1:0] wr_exp;
  logic                 in_fire;
  logic                 out_free;
  logic                 scan_done;
  logic                 push_go;
  logic                 emit_go;
  event_t               emit_kind;
  logic [ID_W-1:0]      emit_id;
  logic                 emit_last;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign scan_done = (state_r == S_SCAN) && (scan_cnt_r == SCN_W'(NUM_TIMERS));
  assign push_go   = (state_r == S_PUSH) && (!have_r || out_free);
  assign wr_exp    = now_r + TIME_BITS'(delay_r);

  assign tok[0] = '0;
  assign idx[0] = '0;

  always_comb begin
    ctl.mode      = mode_r;
    ctl.latch_due = (state_r == S_DUE);
    ctl.wr        = scan_done && (mode_r == REQ_ADD) && tok[NUM_TIMERS].found;
    ctl.clr       = scan_done && (mode_r == REQ_REMOVE) && tok[NUM_TIMERS].found;
    ctl.expire    = push_go;
  end

  for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
    tmr_cell #(
      .TIME_BITS (TIME_BITS),
      .IDX_W     (IDX_W),
      .INDEX     (g)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .hit_idx   (idx[NUM_TIMERS]),
      .wr_id     (idc_r),
      .wr_exp    (wr_exp),
      .wr_rel    (reload_r),
      .now_ms    (now_r),
      .target_id (target_r),
      .tok_in    (tok[g]),
      .idx_in    (idx[g]),
      .tok_out   (tok[g+1]),
      .idx_out   (idx[g+1])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    now_nxt       = now_r;
    idc_nxt       = idc_r;
    mode_nxt      = mode_r;
    delay_nxt     = delay_r;
    reload_nxt    = reload_r;
    target_nxt    = target_r;
    scan_cnt_nxt  = scan_cnt_r;
    cnt_nxt       = cnt_r;
    have_nxt      = have_r;
    pend_kind_nxt = pend_kind_r;
    pend_id_nxt   = pend_id_r;
    emit_go       = 1'b0;
    emit_kind     = pend_kind_r;
    emit_id       = pend_id_r;
    emit_last     = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          mode_nxt     = req_t'(in_tuser[1:0]);
          delay_nxt    = in_tdata[30:0];
          reload_nxt   = in_tdata[61:31];
          target_nxt   = in_tdata[93:62];
          scan_cnt_nxt = '0;
          case (req_t'(in_tuser[1:0]))
            REQ_ADD:    state_nxt = S_SCAN;
            REQ_REMOVE: state_nxt = S_SCAN;
            REQ_TICK: begin
              now_nxt   = now_r + TIME_BITS'(1);
              state_nxt = S_DUE;
            end
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_DUE: begin
        cnt_nxt      = '0;
        have_nxt     = 1'b0;
        scan_cnt_nxt = '0;
        state_nxt    = S_SCAN;
      end
      S_SCAN: begin
        if (!scan_done) begin
          scan_cnt_nxt = scan_cnt_r + SCN_W'(1);
        end else begin
          case (mode_r)
            REQ_ADD: begin
              have_nxt      = 1'b1;
              pend_kind_nxt = tok[NUM_TIMERS].found ? EV_ADDED : EV_FULL;
              pend_id_nxt   = tok[NUM_TIMERS].found ? idc_r : '0;
              if (tok[NUM_TIMERS].found) begin
                idc_nxt = idc_r + ID_W'(1);
              end
              state_nxt = S_LAST;
            end
            REQ_REMOVE: begin
              have_nxt      = 1'b1;
              pend_kind_nxt = tok[NUM_TIMERS].found ? EV_REMOVED : EV_NOTFOUND;
              pend_id_nxt   = tok[NUM_TIMERS].found ? target_r : '0;
              state_nxt     = S_LAST;
            end
            default: begin
              state_nxt = tok[NUM_TIMERS].found ? S_PUSH : S_LAST;
            end
          endcase
        end
      end
      S_PUSH: begin
        // The previous expiry goes out only now that another one follows it.
        if (push_go) begin
          emit_go       = have_r;
          have_nxt      = 1'b1;
          pend_kind_nxt = EV_EXPIRED;
          pend_id_nxt   = tok[NUM_TIMERS].id;
          cnt_nxt       = cnt_r + CNT_W'(1);
          scan_cnt_nxt  = '0;
          state_nxt     = (cnt_r == CNT_W'(MAX_RESULTS - 1)) ? S_LAST : S_SCAN;
        end
      end
      S_LAST: begin
        if (out_free) begin
          emit_go   = 1'b1;
          emit_last = 1'b1;
          emit_kind = have_r ? pend_kind_r : EV_IDLE;
          emit_id   = have_r ? pend_id_r : '0;
          have_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_kind_nxt = out_kind_r;
    out_id_nxt   = out_id_r;
    out_last_nxt = out_last_r;
    if (emit_go) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = emit_kind;
      out_id_nxt    = emit_id;
      out_last_nxt  = emit_last;
    end else begin
      out_valid_nxt = out_valid_r && !out_tready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      now_r       <= '0;
      idc_r       <= '0;
      scan_cnt_r  <= '0;
      cnt_r       <= '0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      now_r       <= now_nxt;
      idc_r       <= idc_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      cnt_r       <= cnt_nxt;
      have_r      <= have_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    delay_r     <= delay_nxt;
    reload_r    <= reload_nxt;
    target_r    <= target_nxt;
    pend_kind_r <= pend_kind_nxt;
    pend_id_r   <= pend_id_nxt;
    out_kind_r  <= out_kind_nxt;
    out_id_r    <= out_id_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_id_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTH
  // A result without the last mark means more results of this item follow.
  a_not_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> (state_r != S_IDLE))
    else $error("non-final result shown while the block is idle");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_RESULTS))
    else $error("expiry count exceeds the per-tick limit");

  // The id counter moves only when an add really stores a timer.
  a_idc_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (idc_r != $past(idc_r))) |-> $past(ctl.wr))
    else $error("id counter advanced without a stored timer");

  a_single_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctl.wr, ctl.clr, ctl.expire, ctl.latch_due}))
    else $error("more than one cell command in a cycle");
`endif

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking testbench for timer_table_oneshot_periodic_core
// Drives add, remove and tick requests on the input stream. A scoreboard class
// keeps its own copy of the timer table and predicts every event, and each
// event taken from the output stream is checked against the oldest prediction.
// The run is split into phases with different amounts of sender and receiver
// idling, and it includes one long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import tmr_pkg::*;

  localparam int SLOTS     = 16;
  localparam int CLK_HALF  = 6;
  localparam int DRAIN_CYC = 400;

  typedef struct packed {
    event_t          kind;
    logic [ID_W-1:0] id;
    logic            last;
  } timer_event_s;

  // Shadow timer table and the queue of events it predicts.
  class timer_scoreboard;
    bit              live [SLOTS];
    bit [ID_W-1:0]   ids [SLOTS];
    bit [39:0]       due_at [SLOTS];
    bit [RELOAD_W-1:0] period [SLOTS];
    bit [39:0]       clock_ms;
    bit [ID_W-1:0]   next_id;
    timer_event_s    pending_q[$];
    int              errors;
    int              n_add, n_remove, n_tick, n_ignored;
    int              n_checked, n_expired, n_full, n_notfound;

    task report_mismatch(input string what);
      errors++;
      $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    function void push_event(input event_t kind, input bit [ID_W-1:0] id);
      timer_event_s ev;
      ev.kind = kind;
      ev.id   = id;
      ev.last = 1'b1;
      pending_q = {pending_q, ev};
    endfunction

    // Records the events that one accepted request will cause.
    function void note_item(input logic [1:0] req, input logic [DELAY_W-1:0] delay,
                            input logic [RELOAD_W-1:0] reload,
                            input logic [ID_W-1:0] target);
      int  slot;
      int  best;
      int  n;
      bit  due [SLOTS];
      slot = -1;
      n    = 0;
      case (req)
        REQ_ADD: begin
          n_add++;
          for (int i = SLOTS - 1; i >= 0; i--) if (!live[i]) slot = i;
          if (slot < 0) begin
            push_event(EV_FULL, '0);
          end else begin
            live[slot]   = 1'b1;
            ids[slot]    = next_id;
            due_at[slot] = clock_ms + 40'(delay);
            period[slot] = reload;
            push_event(EV_ADDED, next_id);
            next_id++;
          end
        end
        REQ_REMOVE: begin
          n_remove++;
          for (int i = SLOTS - 1; i >= 0; i--) if (live[i] && ids[i] == target) slot = i;
          if (slot < 0) begin
            push_event(EV_NOTFOUND, '0);
          end else begin
            live[slot] = 1'b0;
            push_event(EV_REMOVED, target);
          end
        end
        REQ_TICK: begin
          n_tick++;
          clock_ms++;
          for (int i = 0; i < SLOTS; i++) due[i] = live[i] && (due_at[i] <= clock_ms);
          while (n < MAX_RESULTS) begin
            best = -1;
            for (int i = 0; i < SLOTS; i++)
              if (due[i] && (best < 0 || ids[i] < ids[best])) best = i;
            if (best < 0) break;
            due[best] = 1'b0;
            push_event(EV_EXPIRED, ids[best]);
            pending_q[pending_q.size() - 1].last = 1'b0;
            n++;
            if (period[best] != 0) due_at[best] = clock_ms + 40'(period[best]);
            else live[best] = 1'b0;
          end
          if (n == 0) push_event(EV_IDLE, '0);
          else pending_q[pending_q.size() - 1].last = 1'b1;
        end
        default: n_ignored++;
      endcase
    endfunction

    task check_result(input logic [2:0] kind, input logic [ID_W-1:0] id, input logic last);
      timer_event_s ev;
      n_checked++;
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("unexpected event kind %0d id %0d last %0b",
                                  kind, id, last));
      end else begin
        ev = pending_q.pop_front();
        if (kind !== ev.kind)
          report_mismatch($sformatf("event kind %0d, predicted %0d", kind, ev.kind));
        if (id !== ev.id)
          report_mismatch($sformatf("timer id %0d, predicted %0d", id, ev.id));
        if (last !== ev.last)
          report_mismatch($sformatf("last %0b, predicted %0b", last, ev.last));
        if (ev.kind == EV_EXPIRED) n_expired++;
        if (ev.kind == EV_FULL) n_full++;
        if (ev.kind == EV_NOTFOUND) n_notfound++;
      end
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [95:0]         in_tdata;
  logic [1:0]          in_tuser;
  logic                out_tvalid;
  logic                out_tready;
  logic [31:0]         out_tdata;
  logic [2:0]          out_tuser;
  logic                out_tlast;

  timer_scoreboard     sb;
  int                  send_idle_pct;
  int                  recv_idle_pct;
  int                  hold_request;

  timer_table_oneshot_periodic_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Offers one request and returns at the edge where it is accepted.
  task automatic send_request(input logic [1:0] req, input logic [DELAY_W-1:0] delay,
                              input logic [RELOAD_W-1:0] reload,
                              input logic [ID_W-1:0] target);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {2'b00, target, reload, delay};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_item(req, delay, reload, target);
  endtask

  // One random request; most are adds, removes and ticks, and most removes aim at recent ids.
  task automatic send_random;
    int                  pick;
    logic [DELAY_W-1:0]  delay;
    logic [RELOAD_W-1:0] reload;
    logic [ID_W-1:0]     target;
    logic [1:0]          req;
    pick   = $urandom_range(99);
    delay  = ($urandom_range(19) == 0) ? DELAY_W'($urandom) : DELAY_W'($urandom_range(12));
    case ($urandom_range(9))
      0:       reload = RELOAD_W'($urandom);
      1, 2, 3: reload = RELOAD_W'($urandom_range(8, 1));
      default: reload = '0;
    endcase
    if ($urandom_range(9) < 7) target = sb.next_id - 32'($urandom_range(20, 1));
    else target = $urandom;
    if (pick < 35) req = REQ_ADD;
    else if (pick < 55) req = REQ_REMOVE;
    else if (pick < 95) req = REQ_TICK;
    else req = 2'd3;
    send_request(req, delay, reload, target);
  endtask

  // Receiver: checks every accepted event and stalls as the phase asks.
  initial begin
    int hold_left;
    hold_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata, out_tlast);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    #20000000;
    $display("timer_table_oneshot_periodic_core: mismatch");
    $finish;
  end

  initial begin
    sb = new;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= REQ_TICK;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: empty tick, misses, field extremes, one-shot and periodic
    // expiry, an ignored request, a full table and a tick with every slot due.
    send_request(REQ_TICK, '0, '0, '0);
    send_request(REQ_REMOVE, '0, '0, '0);
    send_request(REQ_ADD, '0, '0, '0);
    send_request(REQ_ADD, '1, '1, '1);
    send_request(REQ_ADD, 31'd1, 31'd1, '0);
    send_request(REQ_TICK, '0, '0, '0);
    send_request(REQ_REMOVE, '0, '0, 32'd1);
    send_request(REQ_REMOVE, '0, '0, 32'd1);
    send_request(REQ_REMOVE, '0, '0, '1);
    send_request(2'd3, '1, '1, '1);
    for (int i = 0; i < SLOTS - 1; i++)
      send_request(REQ_ADD, 31'd1, (i % 3 == 0) ? RELOAD_W'(i + 1) : '0, '0);
    send_request(REQ_ADD, 31'd5, 31'd5, '0);
    send_request(REQ_TICK, '0, '0, '0);

    // The receiver holds off for a long stretch while requests keep coming.
    hold_request = 300;
    for (int i = 0; i < 70; i++) send_random();

    send_idle_pct = 66;
    for (int i = 0; i < 70; i++) send_random();

    send_idle_pct = 0;
    recv_idle_pct = 66;
    for (int i = 0; i < 70; i++) send_random();

    send_idle_pct = 13;
    recv_idle_pct = 13;
    for (int i = 0; i < 70; i++) send_random();

    in_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("Covered %0d adds (%0d rejected full), %0d removes (%0d not found), %0d ticks,",
             sb.n_add, sb.n_full, sb.n_remove, sb.n_notfound, sb.n_tick);
    $display("%0d ignored requests and %0d events checked, %0d of them expiries.",
             sb.n_ignored, sb.n_checked, sb.n_expired);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("timer_table_oneshot_periodic_core: match");
    end else begin
      $display("timer_table_oneshot_periodic_core: mismatch");
    end
    $finish;
  end

endmodule
